// ===== sv/hsv2rgb_pkg.sv =====
// Shared word types, field widths and helpers for the HSV to RGB converter.
package hsv2rgb_pkg;

    // Field widths of the input and output words
    localparam int HUE_W   = 15;
    localparam int LEVEL_W = 11;
    localparam int CHAN_W  = 8;

    // Default fixed-point formats
    localparam int HUE_FRAC_BITS_DEF   = 6;
    localparam int LEVEL_FRAC_BITS_DEF = 10;

    // Register stages from input to output
    localparam int NUM_STAGES = 5;

    // Largest channel code
    localparam logic [63:0] CHAN_MAX = 64'd255;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [LEVEL_W-1:0] saturation;
        logic [LEVEL_W-1:0] brightness;
    } t_hsv_word;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb_word;

    // Non-positive numerator gives 0, anything above full scale clips
    function automatic logic [CHAN_W-1:0] chan_sat(input logic pos, input logic [63:0] val);
        logic [CHAN_W-1:0] res;
        if (!pos) begin
            res = '0;
        end else if (val > CHAN_MAX) begin
            res = CHAN_MAX[CHAN_W-1:0];
        end else begin
            res = val[CHAN_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/hsv_to_rgb_converter.sv =====
// Throughput: one word per cycle unless stalled; each of the five register stages
// advances on its own, so bubbles close up and a stalled output word holds while
// earlier stages keep filling.
// Reset (synchronous, active low) clears all stage valid bits; data registers are not reset.
// Top level of the HSV to RGB converter: valid tracking and stall chain around the datapath.
module hsv_to_rgb_converter
    import hsv2rgb_pkg::*;
#(
    parameter int HUE_FRAC_BITS   = HUE_FRAC_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input word channel
    input  logic      i_valid,
    input  t_hsv_word i_word,
    output logic      o_stall,
    // output word channel
    output logic      o_valid,
    output t_rgb_word o_word,
    input  logic      i_stall
);

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] w_ready;

    // A stage may load when it is empty or the stage after it moves on
    always_comb begin
        w_ready[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_ready[k] = !r_vld[k] || w_ready[k+1];
        end
    end

    // Valid bits follow their words
    always_comb begin
        n_vld = r_vld;
        if (w_ready[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (w_ready[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    hsv2rgb_datapath #(
        .HUE_FRAC_BITS   (HUE_FRAC_BITS),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_datapath (
        .i_clk  (i_clk),
        .i_load (w_ready),
        .i_word (i_word),
        .o_word (o_word)
    );

    assign o_stall = !w_ready[0];
    assign o_valid = r_vld[NUM_STAGES-1];

    // Stall only reaches the input once every stage holds a word
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled with an empty stage");

    // An accepted word lands in the first stage
    a_accept_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted word lost at first stage");

    // A held stage keeps its word
    a_hold_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !w_ready[2]) |=> r_vld[1])
        else $error("stalled stage dropped its word");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

endmodule

// ===== sv/hsv2rgb_datapath.sv =====
// Five-stage arithmetic pipeline: sector split, products, channel scaling, selection.
module hsv2rgb_datapath
    import hsv2rgb_pkg::*;
#(
    parameter int HUE_FRAC_BITS   = HUE_FRAC_BITS_DEF,
    parameter int LEVEL_FRAC_BITS = LEVEL_FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic [NUM_STAGES-1:0] i_load,
    input  t_hsv_word             i_word,
    output t_rgb_word             o_word
);

    // Hue span of one sector and level for 1.0
    localparam int H_SPAN = 60 << HUE_FRAC_BITS;
    localparam int L_ONE  = 1 << LEVEL_FRAC_BITS;

    // Internal widths
    localparam int RW   = $clog2(H_SPAN + 1);
    localparam int HL_W = RW + LEVEL_FRAC_BITS;
    localparam int RS_W = RW + LEVEL_W;
    localparam int A_W  = ((HL_W > RS_W) ? HL_W : RS_W) + 1;
    localparam int D_W  = ((LEVEL_FRAC_BITS + 1 > LEVEL_W) ? LEVEL_FRAC_BITS + 1 : LEVEL_W) + 1;
    localparam int V_W  = LEVEL_W + 1;
    localparam int PD_W = V_W + D_W;
    localparam int M_W  = V_W + A_W;
    localparam int CV_W = LEVEL_W + 8;

    // Shifts that replace the denominators; 255/60 is exactly 17/4
    localparam int P_SH = 2 * LEVEL_FRAC_BITS;
    localparam int Q_SH = HUE_FRAC_BITS + 2 * LEVEL_FRAC_BITS + 2;

    localparam longint HL_VAL = longint'(H_SPAN) * longint'(L_ONE);
    localparam logic signed [A_W-1:0] HL_S = A_W'(HL_VAL);
    localparam logic signed [D_W-1:0] L_S  = D_W'(L_ONE);
    localparam logic [RW-1:0] H_U = RW'(H_SPAN);

    typedef enum logic [2:0] {
        SECT_0     = 3'd0,
        SECT_1     = 3'd1,
        SECT_2     = 3'd2,
        SECT_3     = 3'd3,
        SECT_4     = 3'd4,
        SECT_5     = 3'd5,
        SECT_BLACK = 3'd6
    } t_sector;

    // Stage 1 registers
    t_sector             r_s1_sect;
    logic [RW-1:0]       r_s1_r;
    logic [LEVEL_W-1:0]  r_s1_s;
    logic [LEVEL_W-1:0]  r_s1_v;
    // Stage 2 registers
    t_sector             r_s2_sect;
    logic [RS_W-1:0]     r_s2_rs;
    logic [RS_W-1:0]     r_s2_ts;
    logic signed [PD_W-1:0] r_s2_pd;
    logic [CHAN_W-1:0]   r_s2_cv;
    logic [LEVEL_W-1:0]  r_s2_v;
    // Stage 3 registers
    t_sector             r_s3_sect;
    logic signed [A_W-1:0] r_s3_aq;
    logic signed [A_W-1:0] r_s3_at;
    logic [CHAN_W-1:0]   r_s3_cp;
    logic [CHAN_W-1:0]   r_s3_cv;
    logic [LEVEL_W-1:0]  r_s3_v;
    // Stage 4 registers
    t_sector             r_s4_sect;
    logic signed [M_W-1:0] r_s4_mq;
    logic signed [M_W-1:0] r_s4_mt;
    logic [CHAN_W-1:0]   r_s4_cp;
    logic [CHAN_W-1:0]   r_s4_cv;
    // Stage 5 (output) register
    t_rgb_word           r_s5_word;

    // Stage 1: sector by constant compares, remainder within the sector
    t_sector       n_s1_sect;
    logic [31:0]   w_hue32;
    logic [31:0]   w_base;
    logic [RW-1:0] n_s1_r;

    always_comb begin
        w_hue32 = 32'(i_word.hue);
        if (w_hue32 < 32'(H_SPAN)) begin
            n_s1_sect = SECT_0;
            w_base    = '0;
        end else if (w_hue32 < 32'(2 * H_SPAN)) begin
            n_s1_sect = SECT_1;
            w_base    = 32'(H_SPAN);
        end else if (w_hue32 < 32'(3 * H_SPAN)) begin
            n_s1_sect = SECT_2;
            w_base    = 32'(2 * H_SPAN);
        end else if (w_hue32 < 32'(4 * H_SPAN)) begin
            n_s1_sect = SECT_3;
            w_base    = 32'(3 * H_SPAN);
        end else if (w_hue32 < 32'(5 * H_SPAN)) begin
            n_s1_sect = SECT_4;
            w_base    = 32'(4 * H_SPAN);
        end else if (w_hue32 < 32'(6 * H_SPAN)) begin
            n_s1_sect = SECT_5;
            w_base    = 32'(5 * H_SPAN);
        end else begin
            n_s1_sect = SECT_BLACK;
            w_base    = '0;
        end
        n_s1_r = RW'(w_hue32 - w_base);
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r_s1_sect <= n_s1_sect;
            r_s1_r    <= n_s1_r;
            r_s1_s    <= i_word.saturation;
            r_s1_v    <= i_word.brightness;
        end
    end

    // Stage 2: r*s, (H-r)*s, v*(1-s), and the value channel
    logic [RW-1:0]          w_hmr;
    logic signed [D_W-1:0]  w_d;
    logic signed [V_W-1:0]  w_v1;
    logic [CV_W-1:0]        w_cv255;

    always_comb begin
        w_hmr   = H_U - r_s1_r;
        w_d     = L_S - $signed(D_W'(r_s1_s));
        w_v1    = $signed({1'b0, r_s1_v});
        w_cv255 = {r_s1_v, 8'b0} - CV_W'(r_s1_v);
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r_s2_sect <= r_s1_sect;
            r_s2_rs   <= RS_W'(r_s1_r) * RS_W'(r_s1_s);
            r_s2_ts   <= RS_W'(w_hmr) * RS_W'(r_s1_s);
            r_s2_pd   <= PD_W'(w_v1) * PD_W'(w_d);
            r_s2_cv   <= chan_sat(1'b1, 64'(w_cv255 >> LEVEL_FRAC_BITS));
            r_s2_v    <= r_s1_v;
        end
    end

    // Stage 3: 1-fs and 1-(1-f)s terms, and the p channel
    logic                   w_pd_pos;
    logic [PD_W-1:0]        w_pd_u;
    logic [PD_W+7:0]        w_pd255;

    always_comb begin
        w_pd_pos = !r_s2_pd[PD_W-1] && (r_s2_pd != '0);
        w_pd_u   = r_s2_pd;
        w_pd255  = {w_pd_u, 8'b0} - (PD_W+8)'(w_pd_u);
    end

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r_s3_sect <= r_s2_sect;
            r_s3_aq   <= HL_S - $signed(A_W'(r_s2_rs));
            r_s3_at   <= HL_S - $signed(A_W'(r_s2_ts));
            r_s3_cp   <= chan_sat(w_pd_pos, 64'(w_pd255 >> P_SH));
            r_s3_cv   <= r_s2_cv;
            r_s3_v    <= r_s2_v;
        end
    end

    // Stage 4: multiply the q and t terms by v
    logic signed [V_W-1:0] w_v3;

    assign w_v3 = $signed({1'b0, r_s3_v});

    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r_s4_sect <= r_s3_sect;
            r_s4_mq   <= M_W'(w_v3) * M_W'(r_s3_aq);
            r_s4_mt   <= M_W'(w_v3) * M_W'(r_s3_at);
            r_s4_cp   <= r_s3_cp;
            r_s4_cv   <= r_s3_cv;
        end
    end

    // Stage 5: scale q and t by 17/4, clip, route channels by sector
    logic                w_q_pos;
    logic                w_t_pos;
    logic [M_W-1:0]      w_mq_u;
    logic [M_W-1:0]      w_mt_u;
    logic [M_W+3:0]      w_q17;
    logic [M_W+3:0]      w_t17;
    logic [CHAN_W-1:0]   w_cq;
    logic [CHAN_W-1:0]   w_ct;
    t_rgb_word           n_s5_word;

    always_comb begin
        w_q_pos = !r_s4_mq[M_W-1] && (r_s4_mq != '0);
        w_t_pos = !r_s4_mt[M_W-1] && (r_s4_mt != '0);
        w_mq_u  = r_s4_mq;
        w_mt_u  = r_s4_mt;
        w_q17   = {w_mq_u, 4'b0} + (M_W+4)'(w_mq_u);
        w_t17   = {w_mt_u, 4'b0} + (M_W+4)'(w_mt_u);
        w_cq    = chan_sat(w_q_pos, 64'(w_q17 >> Q_SH));
        w_ct    = chan_sat(w_t_pos, 64'(w_t17 >> Q_SH));
        unique case (r_s4_sect)
            SECT_0:  n_s5_word = '{red: r_s4_cv, green: w_ct,    blue: r_s4_cp};
            SECT_1:  n_s5_word = '{red: w_cq,    green: r_s4_cv, blue: r_s4_cp};
            SECT_2:  n_s5_word = '{red: r_s4_cp, green: r_s4_cv, blue: w_ct};
            SECT_3:  n_s5_word = '{red: r_s4_cp, green: w_cq,    blue: r_s4_cv};
            SECT_4:  n_s5_word = '{red: w_ct,    green: r_s4_cp, blue: r_s4_cv};
            SECT_5:  n_s5_word = '{red: r_s4_cv, green: r_s4_cp, blue: w_cq};
            default: n_s5_word = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load[4]) begin
            r_s5_word <= n_s5_word;
        end
    end

    assign o_word = r_s5_word;

endmodule
